>>> src/pbnc_pkg.sv
// shared constants, types and the microprogram of the palette blend block
`timescale 1ns / 1ps
package pbnc_pkg;

	localparam int PALETTE_SIZE = 256;
	localparam int SEARCH_LIMIT = 230;
	localparam int SCAN_LEN     = (SEARCH_LIMIT < PALETTE_SIZE) ? SEARCH_LIMIT : PALETTE_SIZE;
	localparam int ADDR_W       = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

	localparam int CHAN_W  = 8;
	localparam int IDX_W   = 8;
	localparam int SQ_W    = 2 * CHAN_W;
	localparam int DIST_W  = SQ_W + 2;
	localparam int TDATA_W = 40;
	localparam int TUSER_W = 1;
	localparam int MDATA_W = 8;
	localparam int STEP_W  = 3;

	localparam logic [IDX_W-1:0] NO_MATCH_IDX = 8'd255;

	typedef enum logic [0:0] {
		ACT_WRITE = 1'b0,
		ACT_BLEND = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_A,
		RD_B,
		RD_SCAN
	} rd_sel_t;

	typedef enum logic [2:0] {
		C_NONE,
		C_NO_QUERY,
		C_SCAN_MORE,
		C_OUT_BUSY
	} cond_t;

	// program step addresses
	localparam logic [STEP_W-1:0] S_FETCH  = 3'd0;
	localparam logic [STEP_W-1:0] S_RDA    = 3'd1;
	localparam logic [STEP_W-1:0] S_RDB    = 3'd2;
	localparam logic [STEP_W-1:0] S_MIX    = 3'd3;
	localparam logic [STEP_W-1:0] S_SCAN   = 3'd4;
	localparam logic [STEP_W-1:0] S_DRAIN1 = 3'd5;
	localparam logic [STEP_W-1:0] S_DRAIN2 = 3'd6;
	localparam logic [STEP_W-1:0] S_DONE   = 3'd7;

	typedef struct packed {
		logic              in_ready;
		rd_sel_t           rd_sel;
		logic              ld_a;
		logic              ld_mix;
		logic              out_load;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic query_valid;
		logic scan_last;
		logic out_busy;
	} stat_t;

	// control store; S_DONE falls through to S_FETCH as the step counter wraps
	function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{in_ready: 1'b0, rd_sel: RD_NONE, ld_a: 1'b0, ld_mix: 1'b0,
			out_load: 1'b0, cond: C_NONE, target: S_FETCH};
		case (step)
			S_FETCH: begin
				w.in_ready = 1'b1;
				w.cond     = C_NO_QUERY;
				w.target   = S_FETCH;
			end
			S_RDA: begin
				w.rd_sel = RD_A;
			end
			S_RDB: begin
				w.rd_sel = RD_B;
				w.ld_a   = 1'b1;
			end
			S_MIX: begin
				w.ld_mix = 1'b1;
			end
			S_SCAN: begin
				w.rd_sel = RD_SCAN;
				w.cond   = C_SCAN_MORE;
				w.target = S_SCAN;
			end
			S_DRAIN1: begin
				w.cond = C_NONE;
			end
			S_DRAIN2: begin
				w.cond = C_NONE;
			end
			S_DONE: begin
				w.out_load = 1'b1;
				w.cond     = C_OUT_BUSY;
				w.target   = S_DONE;
			end
			default: begin
				w.cond   = C_NONE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> src/palette_blend_nearest_colour.sv
// top level of the palette blend block with nearest colour search
`timescale 1ns / 1ps
// a palette write is stored in the fetch step that accepts it; a blend query scans
// SCAN_LEN (230) entries through the single memory read port, which visits one
// palette entry per cycle; one transaction is worked on at a time; the next is
// accepted while a result waits
// reset clears the step counter, pipeline valids and output valid; palette holds
// whatever it held and is undefined until written
module palette_blend_nearest_colour (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// [7:0] index_a, [15:8] index_b, [23:16] red_in, [31:24] green_in, [39:32] blue_in
	input  logic [pbnc_pkg::TDATA_W-1:0] s_tdata,
	// [0] action
	input  logic [pbnc_pkg::TUSER_W-1:0] s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [7:0] blended_index
	output logic [pbnc_pkg::MDATA_W-1:0] m_tdata
);
	import pbnc_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	// sequencer walks fetch, two entry reads, average, scan loop, drain and deliver
	pbnc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	// input is only taken in the fetch step
	assign s_tready = ctrl.in_ready;

	pbnc_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.stat     (stat),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

>>> src/pbnc_seq.sv
// microprogram sequencer: step counter, control store and jump logic
`timescale 1ns / 1ps
module pbnc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  pbnc_pkg::stat_t stat,
	output pbnc_pkg::ctrl_t ctrl
);
	import pbnc_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_next;
	logic              taken;

	always_comb begin
		ctrl = ucode_rom(step_q);
		case (ctrl.cond)
			C_NONE:      taken = 1'b0;
			C_NO_QUERY:  taken = !stat.query_valid;
			C_SCAN_MORE: taken = !stat.scan_last;
			C_OUT_BUSY:  taken = stat.out_busy;
			default:     taken = 1'b0;
		endcase
		step_next = taken ? ctrl.target : step_q + STEP_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_FETCH;
		end else begin
			step_q <= step_next;
		end
	end

endmodule

>>> src/pbnc_datapath.sv
// palette memory, channel averaging, distance pipeline and best-match tracking
`timescale 1ns / 1ps
module pbnc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pbnc_pkg::ctrl_t                   ctrl,
	output pbnc_pkg::stat_t                   stat,
	input  logic                              s_tvalid,
	input  logic [pbnc_pkg::TDATA_W-1:0]      s_tdata,
	input  logic [pbnc_pkg::TUSER_W-1:0]      s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pbnc_pkg::MDATA_W-1:0]      m_tdata
);
	import pbnc_pkg::*;

	logic [3*CHAN_W-1:0] mem [PALETTE_SIZE];

	logic [IDX_W-1:0]    ia, ib;
	logic [CHAN_W-1:0]   wr_r, wr_g, wr_b;
	logic                accept, ia_in_range;

	logic [IDX_W-1:0]    ia_q, ib_q;
	logic [ADDR_W-1:0]   rd_addr;
	logic                rd_black;
	logic [3*CHAN_W-1:0] rdata_q;
	logic                rd_black_q;
	logic [3*CHAN_W-1:0] rd_color;
	logic [3*CHAN_W-1:0] a_q;
	logic [3*CHAN_W-1:0] mix_q;
	logic [ADDR_W-1:0]   cnt_q;

	logic                v_s1, v_s2;
	logic [ADDR_W-1:0]   idx_s1, idx_s2;
	logic [SQ_W-1:0]     sq_s2 [3];
	logic [SQ_W-1:0]     sq [3];
	logic [DIST_W-1:0]   sum_sq;
	logic [DIST_W-1:0]   best_dist_q;
	logic [IDX_W-1:0]    best_idx_q;

	logic                out_valid_q;
	logic [IDX_W-1:0]    out_idx_q;

	assign ia   = s_tdata[7:0];
	assign ib   = s_tdata[15:8];
	assign wr_r = s_tdata[23:16];
	assign wr_g = s_tdata[31:24];
	assign wr_b = s_tdata[39:32];

	assign accept      = ctrl.in_ready && s_tvalid;
	assign ia_in_range = ({1'b0, ia} < (IDX_W+1)'(PALETTE_SIZE));

	assign stat.query_valid = s_tvalid && (s_tuser[0] == ACT_BLEND);
	assign stat.scan_last   = (cnt_q == ADDR_W'(SCAN_LEN - 1));
	assign stat.out_busy    = out_valid_q && !m_tready;

	// write port, only while fetching
	always_ff @(posedge clk) begin
		if (accept && (s_tuser[0] == ACT_WRITE) && ia_in_range) begin
			mem[ia[ADDR_W-1:0]] <= {wr_b, wr_g, wr_r};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ia_q <= ia;
			ib_q <= ib;
		end
	end

	// read address for the named entries or the scan counter, out-of-range flag for the named ones
	always_comb begin
		case (ctrl.rd_sel)
			RD_A: begin
				rd_addr  = ia_q[ADDR_W-1:0];
				rd_black = !({1'b0, ia_q} < (IDX_W+1)'(PALETTE_SIZE));
			end
			RD_B: begin
				rd_addr  = ib_q[ADDR_W-1:0];
				rd_black = !({1'b0, ib_q} < (IDX_W+1)'(PALETTE_SIZE));
			end
			default: begin
				rd_addr  = cnt_q;
				rd_black = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_sel != RD_NONE) begin
			rdata_q    <= mem[rd_addr];
			rd_black_q <= rd_black;
		end
	end

	assign rd_color = rd_black_q ? '0 : rdata_q;

	// averaged target colour, per channel truncating
	always_ff @(posedge clk) begin
		if (ctrl.ld_a) begin
			a_q <= rd_color;
		end
		if (ctrl.ld_mix) begin
			for (int c = 0; c < 3; c++) begin
				mix_q[c*CHAN_W +: CHAN_W] <= CHAN_W'(({1'b0, a_q[c*CHAN_W +: CHAN_W]}
					+ {1'b0, rd_color[c*CHAN_W +: CHAN_W]}) >> 1);
			end
		end
	end

	// scan counter
	always_ff @(posedge clk) begin
		if (ctrl.ld_mix) begin
			cnt_q <= '0;
		end else if (ctrl.rd_sel == RD_SCAN) begin
			cnt_q <= cnt_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (ctrl.rd_sel == RD_SCAN);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_sel == RD_SCAN) begin
			idx_s1 <= cnt_q;
		end
	end

	// squared channel differences
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [CHAN_W-1:0] p, t, d;
			p = rdata_q[c*CHAN_W +: CHAN_W];
			t = mix_q[c*CHAN_W +: CHAN_W];
			d = (p > t) ? p - t : t - p;
			sq[c] = SQ_W'(d) * SQ_W'(d);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			idx_s2 <= idx_s1;
			for (int c = 0; c < 3; c++) begin
				sq_s2[c] <= sq[c];
			end
		end
	end

	assign sum_sq = DIST_W'(sq_s2[0]) + DIST_W'(sq_s2[1]) + DIST_W'(sq_s2[2]);

	// strict compare keeps the lowest index on ties; all-ones start beats nothing
	always_ff @(posedge clk) begin
		if (ctrl.ld_mix) begin
			best_dist_q <= '1;
			best_idx_q  <= NO_MATCH_IDX;
		end else if (v_s2 && (sum_sq < best_dist_q)) begin
			best_dist_q <= sum_sq;
			best_idx_q  <= IDX_W'(idx_s2);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load && !stat.out_busy) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load && !stat.out_busy) begin
			out_idx_q <= best_idx_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = MDATA_W'(out_idx_q);

endmodule
